@@ rtl/core/integer_factor_image_upsampler_core_assert.svh @@
// Assertion helpers for the upsampler core. Both sample on clk and stay off in reset.
`ifndef INTEGER_FACTOR_IMAGE_UPSAMPLER_CORE_ASSERT_SVH
`define INTEGER_FACTOR_IMAGE_UPSAMPLER_CORE_ASSERT_SVH

// Check a consequence in the same cycle.
`define IFU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the next cycle.
`define IFU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ifu_pkg.sv @@
package ifu_pkg;

	localparam int PIX_W     = 16;
	localparam int MAX_SCALE = 8;
	// Reciprocal divide: q = (x * recip(d)) >> RECIP_SH, exact for x < 2**23
	localparam int RECIP_SH  = 27;
	localparam int RECIP_W   = 28;
	localparam int NUM_W     = 11;
	localparam int DIV_W     = 5;
	localparam int ACC_W     = 26;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		REG_MODE      = 3'd0,
		REG_SCALE_Y   = 3'd1,
		REG_SCALE_X   = 3'd2,
		REG_IN_HEIGHT = 3'd3,
		REG_IN_WIDTH  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic [8:0]              row;
		logic [8:0]              col;
		logic signed [PIX_W-1:0] pixel_in;
	} req_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] pixel_out;
		logic                    status;
	} rsp_t;

	// First tap, tap validity and weights of one axis
	typedef struct packed {
		logic signed [NUM_W-1:0] t0;
		logic                    v0;
		logic                    v1;
		logic [DIV_W-1:0]        w0;
		logic [DIV_W-1:0]        w1;
	} tap_t;

	// ceil(2**27 / d) for divisors 1 to 16
	function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] d);
		logic [RECIP_W-1:0] r;
		case (d)
			5'd1:    r = 28'd134217728;
			5'd2:    r = 28'd67108864;
			5'd3:    r = 28'd44739243;
			5'd4:    r = 28'd33554432;
			5'd5:    r = 28'd26843546;
			5'd6:    r = 28'd22369622;
			5'd7:    r = 28'd19173962;
			5'd8:    r = 28'd16777216;
			5'd9:    r = 28'd14913081;
			5'd10:   r = 28'd13421773;
			5'd11:   r = 28'd12201612;
			5'd12:   r = 28'd11184811;
			5'd13:   r = 28'd10324441;
			5'd14:   r = 28'd9586981;
			5'd15:   r = 28'd8947849;
			5'd16:   r = 28'd8388608;
			default: r = 28'd134217728;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/integer_factor_image_upsampler_core.sv @@
// Structure: a read item passes through 11 register stages before its result is valid.
// Throughput: one item per cycle while the output is not stalled; four parity banks give the 2x2 window in one read.
// The whole pipeline holds while an undelivered result sits in the output stage.
// Reset clears all valid bits and sets mode 0, scales 2, plane size min(MAX_ROWS, 64) x min(MAX_COLS, 64).
// Plane contents are not cleared by reset and are undefined until written.
`include "integer_factor_image_upsampler_core_assert.svh"

module integer_factor_image_upsampler_core #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ifu_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ifu_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [6:0]    cfg_data
);
	import ifu_pkg::*;

	localparam int ROWS_USE = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int COLS_USE = (MAX_COLS < 127) ? MAX_COLS : 127;
	localparam int HRB = (ROWS_USE > 2) ? $clog2((ROWS_USE + 1) / 2) : 1;
	localparam int HCB = (COLS_USE > 2) ? $clog2((COLS_USE + 1) / 2) : 1;
	localparam int AW = HRB + HCB;
	localparam logic [6:0] ROW_MAX = 7'(ROWS_USE);
	localparam logic [6:0] COL_MAX = 7'(COLS_USE);
	localparam logic [6:0] IH_RST = (ROWS_USE < 64) ? 7'(ROWS_USE) : 7'd64;
	localparam logic [6:0] IW_RST = (COLS_USE < 64) ? 7'(COLS_USE) : 7'd64;
	localparam logic [3:0] SC_MAX = 4'(MAX_SCALE);

	function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] hi);
		logic [6:0] r;
		if (v == 7'd0) begin
			r = 7'd1;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic       mode_q;
	logic [3:0] sy_q;
	logic [3:0] sx_q;
	logic [6:0] ih_q;
	logic [6:0] iw_q;

	logic en;

	logic                    v_s1, v_s2, v_s3;
	cmd_t                    cmd_s1, cmd_s2, cmd_s3;
	logic                    err_s1, err_s2, err_s3;
	logic                    wok_s1, wok_s2, wok_s3;
	logic [AW-1:0]           waddr_s1, waddr_s2, waddr_s3;
	logic [1:0]              wsel_s1, wsel_s2, wsel_s3;
	logic signed [PIX_W-1:0] pix_s1, pix_s2, pix_s3;
	logic [NUM_W-1:0]        num_y_s1, num_x_s1;
	logic [DIV_W-1:0]        dv_y_s1, dv_x_s1;

	logic rv_s4, rv_s5, rv_s6, rv_s7, rv_s8, rv_s9, rv_s10, rv_s11;
	logic er_s4, er_s5, er_s6, er_s7, er_s8, er_s9, er_s10, er_s11;

	tap_t tap_y_s3, tap_x_s3, tap_y_s4, tap_x_s4;

	logic [10:0]        lim_y, lim_x;
	logic [3:0][AW-1:0] raddr;
	logic [3:0][PIX_W-1:0] rdata;
	logic               mem_we;
	logic signed [ACC_W-1:0] acc;
	logic signed [PIX_W-1:0] res;

	// Hold clamped configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			sy_q   <= 4'd2;
			sx_q   <= 4'd2;
			ih_q   <= IH_RST;
			iw_q   <= IW_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:      mode_q <= cfg_data[0];
				REG_SCALE_Y:   sy_q   <= 4'(clamp7({3'b000, cfg_data[3:0]}, {3'b000, SC_MAX}));
				REG_SCALE_X:   sx_q   <= 4'(clamp7({3'b000, cfg_data[3:0]}, {3'b000, SC_MAX}));
				REG_IN_HEIGHT: ih_q   <= clamp7(cfg_data, ROW_MAX);
				REG_IN_WIDTH:  iw_q   <= clamp7(cfg_data, COL_MAX);
				default:       ;
			endcase
		end
	end

	// Advance all stages together unless the output is stalled
	assign en        = !rv_s11 || rsp_ready;
	assign req_ready = en;

	always_comb begin
		lim_y = 11'(ih_q) * 11'(sy_q);
		lim_x = 11'(iw_q) * 11'(sx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			rv_s4  <= 1'b0;
			rv_s5  <= 1'b0;
			rv_s6  <= 1'b0;
			rv_s7  <= 1'b0;
			rv_s8  <= 1'b0;
			rv_s9  <= 1'b0;
			rv_s10 <= 1'b0;
			rv_s11 <= 1'b0;
		end else if (en) begin
			v_s1   <= req_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			// drop write items once they reach the plane
			rv_s4  <= v_s3 && (cmd_s3 == CMD_READ);
			rv_s5  <= rv_s4;
			rv_s6  <= rv_s5;
			rv_s7  <= rv_s6;
			rv_s8  <= rv_s7;
			rv_s9  <= rv_s8;
			rv_s10 <= rv_s9;
			rv_s11 <= rv_s10;
		end
	end

	// Capture the item, range checks and axis numerators
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1   <= req.cmd;
			err_s1   <= ({2'b00, req.row} >= lim_y) || ({2'b00, req.col} >= lim_x);
			wok_s1   <= (req.row < {2'b00, ih_q}) && (req.col < {2'b00, iw_q});
			waddr_s1 <= {req.row[HRB:1], req.col[HCB:1]};
			wsel_s1  <= {req.row[0], req.col[0]};
			pix_s1   <= req.pixel_in;
			num_y_s1 <= mode_q ? NUM_W'({req.row, 1'b0}) + NUM_W'(sy_q) + NUM_W'(1)
				: NUM_W'(req.row);
			num_x_s1 <= mode_q ? NUM_W'({req.col, 1'b0}) + NUM_W'(sx_q) + NUM_W'(1)
				: NUM_W'(req.col);
			dv_y_s1  <= mode_q ? {sy_q, 1'b0} : {1'b0, sy_q};
			dv_x_s1  <= mode_q ? {sx_q, 1'b0} : {1'b0, sx_q};

			cmd_s2   <= cmd_s1;
			err_s2   <= err_s1;
			wok_s2   <= wok_s1;
			waddr_s2 <= waddr_s1;
			wsel_s2  <= wsel_s1;
			pix_s2   <= pix_s1;

			cmd_s3   <= cmd_s2;
			err_s3   <= err_s2;
			wok_s3   <= wok_s2;
			waddr_s3 <= waddr_s2;
			wsel_s3  <= wsel_s2;
			pix_s3   <= pix_s2;

			tap_y_s4 <= tap_y_s3;
			tap_x_s4 <= tap_x_s3;
			er_s4    <= err_s3;
			er_s5    <= er_s4;
			er_s6    <= er_s5;
			er_s7    <= er_s6;
			er_s8    <= er_s7;
			er_s9    <= er_s8;
			er_s10   <= er_s9;
			er_s11   <= er_s10;
		end
	end

	ifu_axis u_axis_y (
		.clk  (clk),
		.en   (en),
		.num  (num_y_s1),
		.dv   (dv_y_s1),
		.near (!mode_q),
		.ext  (ih_q),
		.tap  (tap_y_s3)
	);

	ifu_axis u_axis_x (
		.clk  (clk),
		.en   (en),
		.num  (num_x_s1),
		.dv   (dv_x_s1),
		.near (!mode_q),
		.ext  (iw_q),
		.tap  (tap_x_s3)
	);

	// Pick the window row and column that falls in each parity bank
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			logic signed [NUM_W-1:0] ry;
			logic signed [NUM_W-1:0] cx;
			ry = (tap_y_s3.t0[0] == b[1]) ? tap_y_s3.t0 : tap_y_s3.t0 + 11'sd1;
			cx = (tap_x_s3.t0[0] == b[0]) ? tap_x_s3.t0 : tap_x_s3.t0 + 11'sd1;
			raddr[b] = {ry[HRB:1], cx[HCB:1]};
		end
	end

	assign mem_we = v_s3 && (cmd_s3 == CMD_WRITE) && wok_s3;

	ifu_plane_mem #(
		.AW (AW)
	) u_mem (
		.clk   (clk),
		.en    (en),
		.we    (mem_we),
		.wsel  (wsel_s3),
		.waddr (waddr_s3),
		.wdata (pix_s3),
		.raddr (raddr),
		.rdata (rdata)
	);

	ifu_blend u_blend (
		.clk (clk),
		.en  (en),
		.rd  (rdata),
		.ty  (tap_y_s4),
		.tx  (tap_x_s4),
		.acc (acc)
	);

	ifu_round u_round (
		.clk (clk),
		.en  (en),
		.acc (acc),
		.sy  (sy_q),
		.sx  (sx_q),
		.res (res)
	);

	// Present the result, forced to zero on a coordinate error
	assign rsp_valid     = rv_s11;
	assign rsp.pixel_out = er_s11 ? '0 : res;
	assign rsp.status    = er_s11;

	`IFU_ASSERT_NOW(a_err_zero, rsp_valid && rsp.status, rsp.pixel_out == '0,
		"error result carries a nonzero pixel")
	`IFU_ASSERT_NOW(a_stall_only_on_out, !req_ready, rsp_valid && !rsp_ready,
		"input held back without an output stall")
	`IFU_ASSERT_NEXT(a_accept_enters, req_valid && req_ready, v_s1,
		"accepted item missing from the first stage")
	`IFU_ASSERT_NOW(a_cfg_range, 1'b1,
		(sy_q != 4'd0) && (sy_q <= SC_MAX) && (sx_q != 4'd0) && (sx_q <= SC_MAX)
		&& (ih_q != 7'd0) && (iw_q != 7'd0),
		"configuration outside its clamped range")

endmodule

@@ rtl/core/ifu_axis.sv @@
module ifu_axis (
	input  logic                         clk,
	input  logic                         en,
	input  logic [ifu_pkg::NUM_W-1:0]    num,
	input  logic [ifu_pkg::DIV_W-1:0]    dv,
	input  logic                         near,
	input  logic [6:0]                   ext,
	output ifu_pkg::tap_t                tap
);
	import ifu_pkg::*;

	localparam int PW = NUM_W + RECIP_W;
	localparam int QW = 10;

	logic [PW-1:0]    prod_s2;
	logic [NUM_W-1:0] num_s2;
	logic [DIV_W-1:0] dv_s2;
	logic             near_s2;
	logic [6:0]       ext_s2;
	tap_t             tap_s3;

	logic [QW-1:0]           q;
	logic [NUM_W-1:0]        qd;
	logic [DIV_W-1:0]        r;
	logic signed [NUM_W-1:0] t0;
	logic signed [NUM_W-1:0] t1;
	logic signed [NUM_W-1:0] ext_s;
	tap_t                    tap_n;

	// Multiply by the divisor's reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PW'(num) * PW'(recip(dv));
			num_s2  <= num;
			dv_s2   <= dv;
			near_s2 <= near;
			ext_s2  <= ext;
		end
	end

	// Take quotient and remainder, form taps and weights
	always_comb begin
		q     = prod_s2[RECIP_SH +: QW];
		qd    = NUM_W'(NUM_W'(q) * NUM_W'(dv_s2));
		r     = DIV_W'(num_s2 - qd);
		t0    = near_s2 ? $signed({1'b0, q}) : $signed({1'b0, q}) - 11'sd1;
		t1    = t0 + 11'sd1;
		ext_s = $signed({4'b0000, ext_s2});
		tap_n.t0 = t0;
		tap_n.v0 = !t0[NUM_W-1] && (t0 < ext_s);
		tap_n.v1 = !t1[NUM_W-1] && (t1 < ext_s);
		tap_n.w0 = near_s2 ? DIV_W'({dv_s2, 1'b0}) : DIV_W'(dv_s2 - r);
		tap_n.w1 = near_s2 ? '0 : r;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s3 <= tap_n;
		end
	end

	assign tap = tap_s3;

endmodule

@@ rtl/core/ifu_plane_mem.sv @@
module ifu_plane_mem #(
	parameter int AW = 12
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic                                we,
	input  logic [1:0]                          wsel,
	input  logic [AW-1:0]                       waddr,
	input  logic signed [ifu_pkg::PIX_W-1:0]    wdata,
	input  logic [3:0][AW-1:0]                  raddr,
	output logic [3:0][ifu_pkg::PIX_W-1:0]      rdata
);
	import ifu_pkg::*;

	// Four banks by row and column parity, so a 2x2 window reads in one read
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [PIX_W-1:0] mem [2**AW];
		logic [PIX_W-1:0] rd_s4;

		always_ff @(posedge clk) begin
			if (en) begin
				if (we && (wsel == 2'(b))) begin
					mem[waddr] <= wdata;
				end
				rd_s4 <= mem[raddr[b]];
			end
		end

		assign rdata[b] = rd_s4;
	end

endmodule

@@ rtl/core/ifu_blend.sv @@
module ifu_blend (
	input  logic                              clk,
	input  logic                              en,
	input  logic [3:0][ifu_pkg::PIX_W-1:0]    rd,
	input  ifu_pkg::tap_t                     ty,
	input  ifu_pkg::tap_t                     tx,
	output logic signed [ifu_pkg::ACC_W-1:0]  acc
);
	import ifu_pkg::*;

	localparam int HW = PIX_W + DIV_W + 2;

	logic signed [PIX_W-1:0] p [2][2];
	logic signed [HW-1:0]    h_n [2];
	logic signed [HW-1:0]    h_s5 [2];
	logic [DIV_W-1:0]        wy0_s5;
	logic [DIV_W-1:0]        wy1_s5;
	logic signed [ACC_W-1:0] acc_s6;

	// Route banks to window taps, zero taps outside the plane
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			for (int b = 0; b < 2; b++) begin
				logic [1:0] sel;
				logic       ok;
				sel = {ty.t0[0] ^ a[0], tx.t0[0] ^ b[0]};
				ok  = (a[0] ? ty.v1 : ty.v0) && (b[0] ? tx.v1 : tx.v0);
				p[a][b] = ok ? $signed(rd[sel]) : '0;
			end
			h_n[a] = HW'(p[a][0]) * HW'($signed({1'b0, tx.w0}))
				+ HW'(p[a][1]) * HW'($signed({1'b0, tx.w1}));
		end
	end

	// Horizontal blend
	always_ff @(posedge clk) begin
		if (en) begin
			h_s5[0] <= h_n[0];
			h_s5[1] <= h_n[1];
			wy0_s5  <= ty.w0;
			wy1_s5  <= ty.w1;
		end
	end

	// Vertical blend
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s6 <= ACC_W'(h_s5[0]) * ACC_W'($signed({1'b0, wy0_s5}))
				+ ACC_W'(h_s5[1]) * ACC_W'($signed({1'b0, wy1_s5}));
		end
	end

	assign acc = acc_s6;

endmodule

@@ rtl/core/ifu_round.sv @@
module ifu_round (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [ifu_pkg::ACC_W-1:0]  acc,
	input  logic [3:0]                        sy,
	input  logic [3:0]                        sx,
	output logic signed [ifu_pkg::PIX_W-1:0]  res
);
	import ifu_pkg::*;

	localparam int BW = 24;
	localparam int XW = BW - 2;
	localparam int PW = XW + RECIP_W;
	localparam int QW = PIX_W + 1;
	localparam int SW = QW + 1;
	localparam logic signed [SW-1:0] HALF  = SW'(1 << (PIX_W - 1));
	localparam logic signed [SW-1:0] P_MAX = SW'((1 << (PIX_W - 1)) - 1);
	localparam logic signed [SW-1:0] P_MIN = -HALF;

	logic [8:0]              d4;
	logic [BW-1:0]           bias;
	logic signed [BW+2:0]    bsum;
	logic [BW-1:0]           biased;

	logic [PW-1:0] prod_s7;
	logic [XW-1:0] x1_s7;
	logic [1:0]    r0_s7;
	logic [XW-1:0] q1_s8;
	logic [3:0]    r1_s8;
	logic [1:0]    r0_s8;
	logic [PW-1:0] prod_s9;
	logic [XW-1:0] q1_s9;
	logic [3:0]    r1_s9;
	logic [1:0]    r0_s9;
	logic [QW-1:0] q2_s10;
	logic [3:0]    r2_s10;
	logic [3:0]    r1_s10;
	logic [1:0]    r0_s10;
	logic signed [PIX_W-1:0] res_s11;

	logic [XW-1:0]        q1;
	logic [QW-1:0]        q2;
	logic [8:0]           rem;
	logic                 up;
	logic signed [SW-1:0] qv;

	// Offset by 2**15 * d4 so the dividend is never negative
	always_comb begin
		d4     = {7'(7'(sy) * 7'(sx)), 2'b00};
		bias   = BW'(d4) << (PIX_W - 1);
		bsum   = (BW+3)'(acc) + $signed({3'b000, bias});
		biased = bsum[BW-1:0];
	end

	// Divide by 4, then by sy
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s7 <= PW'(biased[BW-1:2]) * PW'(recip({1'b0, sy}));
			x1_s7   <= biased[BW-1:2];
			r0_s7   <= biased[1:0];
		end
	end

	always_comb begin
		q1 = prod_s7[RECIP_SH +: XW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q1_s8 <= q1;
			r1_s8 <= 4'(x1_s7 - XW'(XW'(q1) * XW'(sy)));
			r0_s8 <= r0_s7;
		end
	end

	// Divide by sx
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s9 <= PW'(q1_s8) * PW'(recip({1'b0, sx}));
			q1_s9   <= q1_s8;
			r1_s9   <= r1_s8;
			r0_s9   <= r0_s8;
		end
	end

	always_comb begin
		q2 = prod_s9[RECIP_SH +: QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q2_s10 <= q2;
			r2_s10 <= 4'(q1_s9 - XW'(XW'(q2) * XW'(sx)));
			r1_s10 <= r1_s9;
			r0_s10 <= r0_s9;
		end
	end

	// Rebuild the remainder, round half to even, remove the offset, saturate
	always_comb begin
		rem = {7'(7'(7'(sy) * 7'(r2_s10)) + 7'(r1_s10)), 2'b00} + 9'(r0_s10);
		up  = ({rem, 1'b0} > {1'b0, d4}) || (({rem, 1'b0} == {1'b0, d4}) && q2_s10[0]);
		qv  = $signed({1'b0, q2_s10}) - HALF + SW'(up);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (qv > P_MAX) begin
				res_s11 <= PIX_W'(P_MAX);
			end else if (qv < P_MIN) begin
				res_s11 <= PIX_W'(P_MIN);
			end else begin
				res_s11 <= PIX_W'(qv);
			end
		end
	end

	assign res = res_s11;

endmodule
